### hdl/qpmm_pkg.sv
`timescale 1ns / 1ps

package qpmm_pkg;

    localparam int INTEGRAL_WIDTH = 32;

    localparam int IN_W       = 24;
    localparam int ERR_W      = IN_W + 1;
    localparam int GAIN_W     = 16;
    localparam int DUTY_W     = 8;
    localparam int NUM_AXES   = 3;
    localparam int AXIS_IDX_W = 2;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 2;

    localparam int MUL_A_W = ((INTEGRAL_WIDTH > 32) ? INTEGRAL_WIDTH : 32) + 1;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int DERIV_W = 32;
    localparam int ISUM_W  = ((INTEGRAL_WIDTH > 29) ? INTEGRAL_WIDTH : 29) + 1;
    localparam int INC_SHIFT = 16;
    localparam int I_SHIFT   = 8;

    localparam int BASE_PROD_W = ERR_W + GAIN_W;
    localparam int BASE_X17_W  = BASE_PROD_W + 5;
    localparam int BASE_MAG_W  = BASE_X17_W - 2;
    localparam int BASE_W      = BASE_MAG_W + 1;

    localparam int DIV_RADIX_W = 4;
    localparam int DIV_DIGITS  = (BASE_MAG_W + DIV_RADIX_W - 1) / DIV_RADIX_W;
    localparam int DIV_SRC_W   = DIV_DIGITS * DIV_RADIX_W;
    localparam int DIV_CNT_W   = $clog2(DIV_DIGITS + 1);

    localparam int AXIS_W = ((INTEGRAL_WIDTH + 9 > 48) ? INTEGRAL_WIDTH + 9 : 48) + 2;
    localparam int MIX_W  = AXIS_W + 2;
    localparam int OUT_FRAC = 20;

    localparam logic signed [MUL_B_W-1:0] DT_Q24 = MUL_B_W'(335544);
    localparam logic signed [MUL_P_W-1:0] INC_ROUND = MUL_P_W'(1) <<< (INC_SHIFT - 1);
    localparam logic signed [ISUM_W-1:0]  ISUM_MAX =
        (ISUM_W'(1) <<< (INTEGRAL_WIDTH - 1)) - ISUM_W'(1);
    localparam logic signed [ISUM_W-1:0]  ISUM_MIN = -ISUM_MAX - ISUM_W'(1);
    localparam logic signed [MIX_W-1:0]   DUTY_TOP = MIX_W'(255) <<< OUT_FRAC;
    localparam logic [DUTY_W-1:0]         DUTY_MAX = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd8192;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd205;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd4096;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_BASE = 3'd0;
    localparam logic [OP_W-1:0] OP_DT   = 3'd1;
    localparam logic [OP_W-1:0] OP_P    = 3'd2;
    localparam logic [OP_W-1:0] OP_D    = 3'd3;
    localparam logic [OP_W-1:0] OP_I    = 3'd4;

    typedef struct packed {
        logic                  capture;
        logic                  issue;
        logic [OP_W-1:0]       op;
        logic [AXIS_IDX_W-1:0] axis;
        logic                  mix_en;
        logic                  out_load;
    } qpmm_cmd_t;

    typedef struct packed {
        logic div_busy;
    } qpmm_sts_t;

endpackage

### hdl/quad_pid_motor_mixer_unit.sv
// Thirteen products share one multiplier; no new beat is taken until the result is loaded.
// The throttle division by three runs alongside the multiplier, one hex digit per cycle.
// A finished result waits in the output register while the next beat is taken.
// Reset is synchronous and active low; it restores the gains and clears the PID state.
`timescale 1ns / 1ps

module quad_pid_motor_mixer_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [qpmm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qpmm_pkg::GAIN_W-1:0]       cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [qpmm_pkg::IN_W-1:0]  s_meas_roll,
    input  logic signed [qpmm_pkg::IN_W-1:0]  s_meas_pitch,
    input  logic signed [qpmm_pkg::IN_W-1:0]  s_meas_yaw,
    input  logic signed [qpmm_pkg::IN_W-1:0]  s_meas_altitude,
    input  logic signed [qpmm_pkg::IN_W-1:0]  s_goal_roll,
    input  logic signed [qpmm_pkg::IN_W-1:0]  s_goal_pitch,
    input  logic signed [qpmm_pkg::IN_W-1:0]  s_goal_yaw,
    input  logic signed [qpmm_pkg::IN_W-1:0]  s_goal_altitude,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [qpmm_pkg::DUTY_W-1:0]       m_motor_front_a,
    output logic [qpmm_pkg::DUTY_W-1:0]       m_motor_front_b,
    output logic [qpmm_pkg::DUTY_W-1:0]       m_motor_rear_b,
    output logic [qpmm_pkg::DUTY_W-1:0]       m_motor_rear_a
);

    qpmm_pkg::qpmm_cmd_t cmd;
    qpmm_pkg::qpmm_sts_t sts;

    qpmm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    qpmm_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_meas_roll     (s_meas_roll),
        .s_meas_pitch    (s_meas_pitch),
        .s_meas_yaw      (s_meas_yaw),
        .s_meas_altitude (s_meas_altitude),
        .s_goal_roll     (s_goal_roll),
        .s_goal_pitch    (s_goal_pitch),
        .s_goal_yaw      (s_goal_yaw),
        .s_goal_altitude (s_goal_altitude),
        .m_motor_front_a (m_motor_front_a),
        .m_motor_front_b (m_motor_front_b),
        .m_motor_rear_b  (m_motor_rear_b),
        .m_motor_rear_a  (m_motor_rear_a),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

### hdl/qpmm_div3.sv
`timescale 1ns / 1ps

module qpmm_div3 (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [qpmm_pkg::BASE_MAG_W-1:0]  mag_in,
    output logic                             busy,
    output logic [qpmm_pkg::BASE_MAG_W-1:0]  quot
);

    logic [qpmm_pkg::DIV_SRC_W-1:0]   src_reg;
    logic [qpmm_pkg::DIV_SRC_W-1:0]   quot_reg;
    logic [1:0]                       rem_reg;
    logic [qpmm_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [qpmm_pkg::DIV_RADIX_W-1:0] digit_q;
    logic [1:0]                       rem_next;
    logic [2:0]                       part;

    // Restoring division by three, one radix-16 digit per cycle.
    always_comb begin
        part = {1'b0, rem_reg};
        for (int i = qpmm_pkg::DIV_RADIX_W - 1; i >= 0; i--) begin
            part = {part[1:0], src_reg[qpmm_pkg::DIV_SRC_W - qpmm_pkg::DIV_RADIX_W + i]};
            if (part >= 3'd3) begin
                digit_q[i] = 1'b1;
                part       = part - 3'd3;
            end else begin
                digit_q[i] = 1'b0;
            end
        end
        rem_next = part[1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg  <= qpmm_pkg::DIV_CNT_W'(qpmm_pkg::DIV_DIGITS);
            src_reg  <= qpmm_pkg::DIV_SRC_W'(mag_in);
            rem_reg  <= 2'd0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - qpmm_pkg::DIV_CNT_W'(1);
            src_reg  <= src_reg << qpmm_pkg::DIV_RADIX_W;
            quot_reg <= {quot_reg[qpmm_pkg::DIV_SRC_W-qpmm_pkg::DIV_RADIX_W-1:0], digit_q};
            rem_reg  <= rem_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg[qpmm_pkg::BASE_MAG_W-1:0];

endmodule

### hdl/qpmm_dp.sv
`timescale 1ns / 1ps

module qpmm_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [qpmm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qpmm_pkg::GAIN_W-1:0]          cfg_wdata,
    input  logic signed [qpmm_pkg::IN_W-1:0]     s_meas_roll,
    input  logic signed [qpmm_pkg::IN_W-1:0]     s_meas_pitch,
    input  logic signed [qpmm_pkg::IN_W-1:0]     s_meas_yaw,
    input  logic signed [qpmm_pkg::IN_W-1:0]     s_meas_altitude,
    input  logic signed [qpmm_pkg::IN_W-1:0]     s_goal_roll,
    input  logic signed [qpmm_pkg::IN_W-1:0]     s_goal_pitch,
    input  logic signed [qpmm_pkg::IN_W-1:0]     s_goal_yaw,
    input  logic signed [qpmm_pkg::IN_W-1:0]     s_goal_altitude,
    output logic [qpmm_pkg::DUTY_W-1:0]          m_motor_front_a,
    output logic [qpmm_pkg::DUTY_W-1:0]          m_motor_front_b,
    output logic [qpmm_pkg::DUTY_W-1:0]          m_motor_rear_b,
    output logic [qpmm_pkg::DUTY_W-1:0]          m_motor_rear_a,
    input  qpmm_pkg::qpmm_cmd_t                  cmd,
    output qpmm_pkg::qpmm_sts_t                  sts
);

    logic [qpmm_pkg::GAIN_W-1:0]                gain_p_reg;
    logic [qpmm_pkg::GAIN_W-1:0]                gain_i_reg;
    logic [qpmm_pkg::GAIN_W-1:0]                gain_d_reg;

    logic signed [qpmm_pkg::ERR_W-1:0]          err_reg [qpmm_pkg::NUM_AXES];
    logic signed [qpmm_pkg::ERR_W-1:0]          alt_err_reg;
    logic signed [qpmm_pkg::INTEGRAL_WIDTH-1:0] int_reg [qpmm_pkg::NUM_AXES];
    logic signed [qpmm_pkg::ERR_W-1:0]          prev_reg [qpmm_pkg::NUM_AXES];
    logic signed [qpmm_pkg::AXIS_W-1:0]         axis_reg [qpmm_pkg::NUM_AXES];
    logic signed [qpmm_pkg::MIX_W-1:0]          mix_reg [4];

    logic signed [qpmm_pkg::MUL_P_W-1:0]        prod_reg;
    logic [qpmm_pkg::OP_W-1:0]                  tag_op_reg;
    logic [qpmm_pkg::AXIS_IDX_W-1:0]            tag_ax_reg;
    logic                                       tag_vld_reg;
    logic                                       base_neg_reg;

    logic [qpmm_pkg::DUTY_W-1:0]                front_a_reg;
    logic [qpmm_pkg::DUTY_W-1:0]                front_b_reg;
    logic [qpmm_pkg::DUTY_W-1:0]                rear_b_reg;
    logic [qpmm_pkg::DUTY_W-1:0]                rear_a_reg;

    logic signed [qpmm_pkg::ERR_W-1:0]          err_sel;
    logic signed [qpmm_pkg::ERR_W:0]            diff;
    logic signed [qpmm_pkg::DERIV_W-1:0]        diff_w;
    logic signed [qpmm_pkg::DERIV_W-1:0]        deriv;
    logic signed [qpmm_pkg::MUL_A_W-1:0]        mul_a;
    logic signed [qpmm_pkg::MUL_B_W-1:0]        mul_b;

    logic signed [qpmm_pkg::MUL_P_W-1:0]        inc_full;
    logic signed [qpmm_pkg::ISUM_W-1:0]         isum;
    logic signed [qpmm_pkg::INTEGRAL_WIDTH-1:0] int_new;
    logic signed [qpmm_pkg::AXIS_W-1:0]         term;

    logic signed [qpmm_pkg::BASE_X17_W-1:0]     base_px;
    logic signed [qpmm_pkg::BASE_X17_W-1:0]     base_x17;
    logic [qpmm_pkg::BASE_X17_W-1:0]            base_abs;
    logic                                       div_start;
    logic                                       div_busy;
    logic [qpmm_pkg::BASE_MAG_W-1:0]            div_quot;
    logic signed [qpmm_pkg::BASE_W-1:0]         base_pos;
    logic signed [qpmm_pkg::BASE_W-1:0]         base_val;

    logic signed [qpmm_pkg::MIX_W-1:0]          mb;
    logic signed [qpmm_pkg::MIX_W-1:0]          mr;
    logic signed [qpmm_pkg::MIX_W-1:0]          mp;
    logic signed [qpmm_pkg::MIX_W-1:0]          my;

    function automatic logic [qpmm_pkg::DUTY_W-1:0] to_duty(
        input logic signed [qpmm_pkg::MIX_W-1:0] m
    );
        logic [qpmm_pkg::DUTY_W-1:0] d;
        if (m[qpmm_pkg::MIX_W-1]) begin
            d = '0;
        end else if (m > qpmm_pkg::DUTY_TOP) begin
            d = qpmm_pkg::DUTY_MAX;
        end else begin
            d = m[qpmm_pkg::OUT_FRAC+qpmm_pkg::DUTY_W-1:qpmm_pkg::OUT_FRAC];
        end
        return d;
    endfunction

    function automatic logic signed [qpmm_pkg::ERR_W:0] ERR_W_EXT(
        input logic signed [qpmm_pkg::ERR_W-1:0] v
    );
        return (qpmm_pkg::ERR_W + 1)'(v);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg <= qpmm_pkg::GAIN_P_RST;
            gain_i_reg <= qpmm_pkg::GAIN_I_RST;
            gain_d_reg <= qpmm_pkg::GAIN_D_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                qpmm_pkg::REG_GAIN_P: begin
                    gain_p_reg <= cfg_wdata;
                end
                qpmm_pkg::REG_GAIN_I: begin
                    gain_i_reg <= cfg_wdata;
                end
                qpmm_pkg::REG_GAIN_D: begin
                    gain_d_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        err_sel = err_reg[cmd.axis];
        diff    = qpmm_pkg::ERR_W'(0) + (ERR_W_EXT(err_sel) - ERR_W_EXT(prev_reg[cmd.axis]));
        diff_w  = qpmm_pkg::DERIV_W'(diff);
        deriv   = (diff_w <<< 5) + (diff_w <<< 4) + (diff_w <<< 1);
        unique case (cmd.op)
            qpmm_pkg::OP_BASE: begin
                mul_a = qpmm_pkg::MUL_A_W'(alt_err_reg);
                mul_b = qpmm_pkg::MUL_B_W'(gain_p_reg);
            end
            qpmm_pkg::OP_DT: begin
                mul_a = qpmm_pkg::MUL_A_W'(err_sel);
                mul_b = qpmm_pkg::DT_Q24;
            end
            qpmm_pkg::OP_P: begin
                mul_a = qpmm_pkg::MUL_A_W'(err_sel);
                mul_b = qpmm_pkg::MUL_B_W'(gain_p_reg);
            end
            qpmm_pkg::OP_D: begin
                mul_a = qpmm_pkg::MUL_A_W'(deriv);
                mul_b = qpmm_pkg::MUL_B_W'(gain_d_reg);
            end
            qpmm_pkg::OP_I: begin
                mul_a = qpmm_pkg::MUL_A_W'(int_reg[cmd.axis]);
                mul_b = qpmm_pkg::MUL_B_W'(gain_i_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Second stage: fold the registered product into axis or base.
    always_comb begin
        inc_full = (prod_reg + qpmm_pkg::INC_ROUND) >>> qpmm_pkg::INC_SHIFT;
        isum     = qpmm_pkg::ISUM_W'(int_reg[tag_ax_reg]) + qpmm_pkg::ISUM_W'(inc_full);
        if (isum > qpmm_pkg::ISUM_MAX) begin
            int_new = qpmm_pkg::ISUM_MAX[qpmm_pkg::INTEGRAL_WIDTH-1:0];
        end else if (isum < qpmm_pkg::ISUM_MIN) begin
            int_new = qpmm_pkg::ISUM_MIN[qpmm_pkg::INTEGRAL_WIDTH-1:0];
        end else begin
            int_new = isum[qpmm_pkg::INTEGRAL_WIDTH-1:0];
        end
        if (tag_op_reg == qpmm_pkg::OP_I) begin
            term = qpmm_pkg::AXIS_W'(prod_reg >>> qpmm_pkg::I_SHIFT);
        end else begin
            term = qpmm_pkg::AXIS_W'(prod_reg);
        end
        base_px   = qpmm_pkg::BASE_X17_W'(prod_reg);
        base_x17  = (base_px <<< 4) + base_px;
        base_abs  = base_x17[qpmm_pkg::BASE_X17_W-1] ? -base_x17 : base_x17;
        div_start = tag_vld_reg && (tag_op_reg == qpmm_pkg::OP_BASE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_vld_reg <= 1'b0;
            for (int k = 0; k < qpmm_pkg::NUM_AXES; k++) begin
                int_reg[k]  <= '0;
                prev_reg[k] <= '0;
            end
        end else begin
            tag_vld_reg <= cmd.issue;
            if (cmd.issue && (cmd.op == qpmm_pkg::OP_D)) begin
                prev_reg[cmd.axis] <= err_sel;
            end
            if (tag_vld_reg && (tag_op_reg == qpmm_pkg::OP_DT)) begin
                int_reg[tag_ax_reg] <= int_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            err_reg[0]  <= qpmm_pkg::ERR_W'(s_goal_roll) - qpmm_pkg::ERR_W'(s_meas_roll);
            err_reg[1]  <= qpmm_pkg::ERR_W'(s_goal_pitch) - qpmm_pkg::ERR_W'(s_meas_pitch);
            err_reg[2]  <= qpmm_pkg::ERR_W'(s_goal_yaw) - qpmm_pkg::ERR_W'(s_meas_yaw);
            alt_err_reg <= qpmm_pkg::ERR_W'(s_goal_altitude)
                           - qpmm_pkg::ERR_W'(s_meas_altitude);
        end
        if (cmd.issue) begin
            prod_reg   <= mul_a * mul_b;
            tag_op_reg <= cmd.op;
            tag_ax_reg <= cmd.axis;
        end
        if (tag_vld_reg) begin
            unique case (tag_op_reg) inside
                qpmm_pkg::OP_BASE: begin
                    base_neg_reg <= base_x17[qpmm_pkg::BASE_X17_W-1];
                end
                qpmm_pkg::OP_P: begin
                    axis_reg[tag_ax_reg] <= term;
                end
                qpmm_pkg::OP_D, qpmm_pkg::OP_I: begin
                    axis_reg[tag_ax_reg] <= axis_reg[tag_ax_reg] + term;
                end
                default: begin
                end
            endcase
        end
        if (cmd.mix_en) begin
            mix_reg[0] <= mb + mr - mp + my;
            mix_reg[1] <= mb - mr - mp - my;
            mix_reg[2] <= mb - mr + mp + my;
            mix_reg[3] <= mb + mr + mp - my;
        end
        if (cmd.out_load) begin
            front_a_reg <= to_duty(mix_reg[0]);
            front_b_reg <= to_duty(mix_reg[1]);
            rear_b_reg  <= to_duty(mix_reg[2]);
            rear_a_reg  <= to_duty(mix_reg[3]);
        end
    end

    qpmm_div3 u_div3 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag_in  (base_abs[qpmm_pkg::BASE_X17_W-1:2]),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    assign base_pos = qpmm_pkg::BASE_W'(div_quot);
    assign base_val = base_neg_reg ? -base_pos : base_pos;

    assign mb = qpmm_pkg::MIX_W'(base_val);
    assign mr = qpmm_pkg::MIX_W'(axis_reg[0]);
    assign mp = qpmm_pkg::MIX_W'(axis_reg[1]);
    assign my = qpmm_pkg::MIX_W'(axis_reg[2]);

    assign sts.div_busy = div_busy;

    assign m_motor_front_a = front_a_reg;
    assign m_motor_front_b = front_b_reg;
    assign m_motor_rear_b  = rear_b_reg;
    assign m_motor_rear_a  = rear_a_reg;

endmodule

### hdl/qpmm_ctrl.sv
`timescale 1ns / 1ps

module qpmm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output qpmm_pkg::qpmm_cmd_t  cmd,
    input  qpmm_pkg::qpmm_sts_t  sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BASE  = 3'd1;
    localparam logic [2:0] S_AXIS  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_MIX   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [qpmm_pkg::AXIS_IDX_W-1:0] LAST_AXIS =
        qpmm_pkg::AXIS_IDX_W'(qpmm_pkg::NUM_AXES - 1);
    localparam logic [qpmm_pkg::PHASE_W-1:0] LAST_PHASE = '1;

    logic [2:0]                      state_reg;
    logic [2:0]                      state_next;
    logic [qpmm_pkg::AXIS_IDX_W-1:0] axis_reg;
    logic [qpmm_pkg::AXIS_IDX_W-1:0] axis_next;
    logic [qpmm_pkg::PHASE_W-1:0]    phase_reg;
    logic [qpmm_pkg::PHASE_W-1:0]    phase_next;
    logic                            m_valid_reg;
    logic                            m_valid_next;

    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        phase_next   = phase_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_BASE;
                end
            end
            S_BASE: begin
                cmd.issue  = 1'b1;
                cmd.op     = qpmm_pkg::OP_BASE;
                axis_next  = '0;
                phase_next = '0;
                state_next = S_AXIS;
            end
            S_AXIS: begin
                cmd.issue  = 1'b1;
                cmd.axis   = axis_reg;
                phase_next = phase_reg + qpmm_pkg::PHASE_W'(1);
                case (phase_reg)
                    2'd0:    cmd.op = qpmm_pkg::OP_DT;
                    2'd1:    cmd.op = qpmm_pkg::OP_P;
                    2'd2:    cmd.op = qpmm_pkg::OP_D;
                    default: cmd.op = qpmm_pkg::OP_I;
                endcase
                if (phase_reg == LAST_PHASE) begin
                    if (axis_reg == LAST_AXIS) begin
                        state_next = S_DRAIN;
                    end else begin
                        axis_next = axis_reg + qpmm_pkg::AXIS_IDX_W'(1);
                    end
                end
            end
            S_DRAIN: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (!sts.div_busy) begin
                    state_next = S_MIX;
                end
            end
            S_MIX: begin
                cmd.mix_en = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            axis_reg    <= '0;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### hdl/qpmm_checker.sv
`timescale 1ns / 1ps

module qpmm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [qpmm_pkg::DUTY_W-1:0] m_motor_front_a,
    input logic [qpmm_pkg::DUTY_W-1:0] m_motor_front_b,
    input logic [qpmm_pkg::DUTY_W-1:0] m_motor_rear_b,
    input logic [qpmm_pkg::DUTY_W-1:0] m_motor_rear_a
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_motor_front_a)
            && $stable(m_motor_front_b) && $stable(m_motor_rear_b)
            && $stable(m_motor_rear_a))
        else $error("result beat changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input taken again while a beat is in work");

    a_result_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result posted while the unit is still busy");

endmodule

bind quad_pid_motor_mixer_unit qpmm_checker u_qpmm_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_motor_front_a (m_motor_front_a),
    .m_motor_front_b (m_motor_front_b),
    .m_motor_rear_b  (m_motor_rear_b),
    .m_motor_rear_a  (m_motor_rear_a)
);
